/* rtl/stq_pkg.sv */
// shared types and codes for the sorted timer expiry queue
`timescale 1ns / 1ps
package stq_pkg;

	localparam logic [2:0] FUNC_SCHEDULE = 3'd0;
	localparam logic [2:0] FUNC_CANCEL   = 3'd1;
	localparam logic [2:0] FUNC_TICK     = 3'd2;
	localparam logic [2:0] FUNC_QUERY    = 3'd3;
	localparam logic [2:0] FUNC_SET_PER  = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	localparam logic [47:0] TIME_MAX  = {48{1'b1}};
	localparam logic [30:0] COUNT_MAX = {31{1'b1}};

	typedef struct packed {
		logic        valid;
		// already fired in the tick in progress
		logic        done;
		logic [47:0] expire;
		logic [31:0] period;
		logic [30:0] limit;
		logic [30:0] count;
		logic [31:0] ident;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_POP
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t    op;
		logic        set_per;
		logic        clr_done;
		entry_t      ent;
		logic [31:0] key_id;
	} cell_cmd_t;

	// chain signals handed from one cell to the next
	typedef struct packed {
		logic        take;
		logic        found;
		logic [31:0] period;
	} chain_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_id;
		logic        fired;
		logic [30:0] fire_count;
		logic [31:0] period_out;
		logic        is_oneshot;
		logic [4:0]  expired_total;
		logic        last_result;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REINS
	} state_t;

endpackage

/* rtl/stq_cell.sv */
// one slot of the sorted timer row
`timescale 1ns / 1ps
module stq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::cell_cmd_t cmd,
	input  stq_pkg::entry_t    prev_ent,
	input  stq_pkg::chain_t    prev_chain,
	input  stq_pkg::entry_t    next_ent,
	output stq_pkg::entry_t    ent,
	output stq_pkg::chain_t    chain
);

	stq_pkg::entry_t ent_q;
	logic            take;
	logic            match;
	logic            here;

	// a refired entry goes in front of the earlier refired ones
	assign take  = !ent_q.valid || (cmd.ent.done ? ent_q.done :
		(ent_q.expire >= cmd.ent.expire));
	assign match = ent_q.valid && (ent_q.ident == cmd.key_id);
	assign here  = prev_chain.found || match;

	assign chain.take   = prev_chain.take || take;
	assign chain.found  = here;
	// first match in list order wins
	assign chain.period = prev_chain.found ? prev_chain.period :
		(match ? ent_q.period : 32'd0);

	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			case (cmd.op)
				stq_pkg::CMD_INSERT: begin
					if (prev_chain.take) begin
						ent_q <= prev_ent;
					end else if (take) begin
						ent_q <= cmd.ent;
					end
				end
				stq_pkg::CMD_REMOVE: begin
					if (here) begin
						ent_q <= next_ent;
					end
				end
				stq_pkg::CMD_POP: begin
					ent_q <= next_ent;
				end
				default: begin
					if (cmd.set_per && match && !prev_chain.found) begin
						ent_q.period <= cmd.ent.period;
					end
					if (cmd.clr_done) begin
						ent_q.done <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/sorted_timer_expiry_queue_core.sv */
// sorted timer expiry queue: control sequencer and row of timer cells
`timescale 1ns / 1ps
// Commands come in on the s_ channel, one item per command; func rides in
// s_tuser. Results leave on the m_ channel; m_tlast marks the final result
// of a command. Timers live in a row of ENTRIES cells kept sorted by expiry
// time, each cell comparing against a broadcast key and shifting to its
// neighbor. An accepted schedule, cancel, query or set-period item is
// registered and executed in ST_EXEC, which writes its result to the
// output register; the sequencer then returns to ST_IDLE before it can
// accept the next item. A tick pops each fired timer in ST_EXEC and
// passes each rescheduled one through ST_REINS (pop, then sorted insert)
// before its final result. One command is in work at a time;
// s_tready is high while the sequencer is idle, even if a result still
// waits on m_. When m_tready is low the result waits in the output register
// and the sequencer holds before writing the next one, so nothing is lost.
// Reset empties the row and sets the id counter to 1; the first command may
// be taken right after reset.
module sorted_timer_expiry_queue_core #(
	parameter int ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// when_time[47:0], period_in[79:48], fire_limit[110:80], timer_id[142:111]
	input  logic [143:0] s_tdata,
	// func[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_id[31:0], fired[32], fire_count[63:33], period_out[95:64],
	// is_oneshot[96], expired_total[101:97]
	output logic [103:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	stq_pkg::state_t    state_q, state_n;
	logic [2:0]         func_q;
	logic [47:0]        when_q;
	logic [31:0]        per_q;
	logic [30:0]        lim_q;
	logic [31:0]        id_q;
	logic [4:0]         nfired_q, nfired_n;
	logic [31:0]        next_ident_q, next_ident_n;
	stq_pkg::entry_t    reins_q, reins_n;
	stq_pkg::result_t   res_q, res_n;
	logic               m_valid_q;
	logic               emit;
	stq_pkg::cell_cmd_t cmd;

	stq_pkg::entry_t    ents  [ENTRIES];
	stq_pkg::chain_t    chains[ENTRIES];

	logic               out_free;
	stq_pkg::entry_t    head;
	logic               full;
	logic               found;
	logic [30:0]        cnt_inc;
	logic [48:0]        sum_t;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			stq_pkg::entry_t pe, ne;
			stq_pkg::chain_t pc;
			if (g == 0) begin : g_first
				assign pe = '0;
				assign pc = '0;
			end else begin : g_mid
				assign pe = ents[g-1];
				assign pc = chains[g-1];
			end
			if (g == ENTRIES - 1) begin : g_last
				assign ne = '0;
			end else begin : g_inner
				assign ne = ents[g+1];
			end
			stq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.prev_ent   (pe),
				.prev_chain (pc),
				.next_ent   (ne),
				.ent        (ents[g]),
				.chain      (chains[g])
			);
		end
	endgenerate

	assign head     = ents[0];
	assign full     = ents[ENTRIES-1].valid;
	assign found    = chains[ENTRIES-1].found;
	assign out_free = !m_valid_q || m_tready;
	assign cnt_inc  = (head.count < stq_pkg::COUNT_MAX) ? head.count + 31'd1 : head.count;
	assign sum_t    = {1'b0, when_q} + {17'd0, head.period};

	assign s_tready = (state_q == stq_pkg::ST_IDLE);

	always_comb begin
		state_n      = state_q;
		nfired_n     = nfired_q;
		next_ident_n = next_ident_q;
		reins_n      = reins_q;
		res_n        = '0;
		emit         = 1'b0;
		cmd.op       = stq_pkg::CMD_NONE;
		cmd.set_per  = 1'b0;
		cmd.clr_done = 1'b0;
		cmd.ent      = '0;
		cmd.key_id   = id_q;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				nfired_n = 5'd0;
				if (s_tvalid) begin
					state_n = stq_pkg::ST_EXEC;
				end
			end
			stq_pkg::ST_EXEC: begin
				if (out_free) begin
					res_n.last_result = 1'b1;
					emit              = 1'b1;
					state_n           = stq_pkg::ST_IDLE;
					case (func_q)
						stq_pkg::FUNC_SCHEDULE: begin
							if (full) begin
								res_n.status = stq_pkg::STATUS_FULL;
							end else begin
								cmd.op           = stq_pkg::CMD_INSERT;
								cmd.ent.valid    = 1'b1;
								cmd.ent.expire   = when_q;
								cmd.ent.period   = per_q;
								cmd.ent.limit    = lim_q;
								cmd.ent.count    = 31'd0;
								cmd.ent.ident    = next_ident_q;
								res_n.result_id  = next_ident_q;
								next_ident_n     = next_ident_q + 32'd1;
							end
						end
						stq_pkg::FUNC_CANCEL: begin
							cmd.op = stq_pkg::CMD_REMOVE;
							if (!found) begin
								res_n.status = stq_pkg::STATUS_NOT_FOUND;
							end
						end
						stq_pkg::FUNC_TICK: begin
							if (head.valid && !head.done && head.expire <= when_q) begin
								cmd.op            = stq_pkg::CMD_POP;
								res_n.last_result = 1'b0;
								res_n.fired       = 1'b1;
								res_n.result_id   = head.ident;
								res_n.fire_count  = cnt_inc;
								nfired_n          = nfired_q + 5'd1;
								reins_n           = head;
								reins_n.count     = cnt_inc;
								reins_n.expire    = sum_t[48] ? stq_pkg::TIME_MAX : sum_t[47:0];
								reins_n.done      = (when_q == stq_pkg::TIME_MAX);
								if (head.period != 32'd0 &&
									!(head.limit != 31'd0 && cnt_inc >= head.limit)) begin
									state_n = stq_pkg::ST_REINS;
								end else begin
									state_n = stq_pkg::ST_EXEC;
								end
							end else begin
								res_n.expired_total = nfired_q;
								cmd.clr_done        = 1'b1;
							end
						end
						stq_pkg::FUNC_QUERY: begin
							if (found) begin
								res_n.period_out = chains[ENTRIES-1].period;
								res_n.is_oneshot = (chains[ENTRIES-1].period == 32'd0);
							end else begin
								res_n.status = stq_pkg::STATUS_NOT_FOUND;
							end
						end
						stq_pkg::FUNC_SET_PER: begin
							cmd.set_per    = 1'b1;
							cmd.ent.period = per_q;
							if (!found) begin
								res_n.status = stq_pkg::STATUS_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			stq_pkg::ST_REINS: begin
				// rescheduled time is past now, except at the top of the time
				// range, where the done mark keeps the entry from firing again
				cmd.op  = stq_pkg::CMD_INSERT;
				cmd.ent = reins_q;
				state_n = stq_pkg::ST_EXEC;
			end
			default: begin
				state_n = stq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= stq_pkg::ST_IDLE;
			next_ident_q <= 32'd1;
			nfired_q     <= 5'd0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q      <= state_n;
			next_ident_q <= next_ident_n;
			nfired_q     <= nfired_n;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			when_q <= s_tdata[47:0];
			per_q  <= s_tdata[79:48];
			lim_q  <= s_tdata[110:80];
			id_q   <= s_tdata[142:111];
		end
		reins_q <= reins_n;
		if (emit) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last_result;
	assign m_tdata  = {2'b00, res_q.expired_total, res_q.is_oneshot, res_q.period_out,
		res_q.fire_count, res_q.fired, res_q.result_id};

endmodule
